// File: sv/gmt_pkg.sv
// gossip membership table package
// shared constants and types, no dependencies
package gmt_pkg;
  localparam int TableDepthDef = 16;

  localparam logic [1:0] ACT_MERGE = 2'd0;
  localparam logic [1:0] ACT_JOIN  = 2'd1;
  localparam logic [1:0] ACT_TICK  = 2'd2;
  localparam logic [1:0] ACT_LIST  = 2'd3;

  localparam logic [2:0] MS_NONE  = 3'd0;
  localparam logic [2:0] MS_UPD   = 3'd1;
  localparam logic [2:0] MS_SAME  = 3'd2;
  localparam logic [2:0] MS_INS   = 3'd3;
  localparam logic [2:0] MS_FULL  = 3'd4;

  localparam logic [2:0] REG_FAIL  = 3'd0;
  localparam logic [2:0] REG_REM   = 3'd1;
  localparam logic [2:0] REG_ID    = 3'd2;
  localparam logic [2:0] REG_PORT  = 3'd3;
  localparam logic [2:0] REG_INTRO = 3'd4;

  typedef struct packed {
    logic [31:0] id;
    logic [15:0] port;
    logic [31:0] hb;
    logic [31:0] stamp;
  } entry_t;

  // per-cycle command broadcast to every cell
  typedef struct packed {
    logic        shift;   // move every word one cell toward the head
    logic        merge;   // compare and update against key
    logic [31:0] key_id;
    logic [15:0] key_port;
    logic [31:0] key_hb;
    logic [31:0] now;
    logic [15:0] fail;
    logic [16:0] limit;
    entry_t      ins;     // word taken by the selected cell
  } cell_cmd_t;

  // one result transaction
  typedef struct packed {
    logic        ev;
    logic [31:0] id;
    logic [15:0] port;
    logic [31:0] hb;
    logic [31:0] lt;
    logic [2:0]  ms;
    logic [3:0]  rc;
    logic        last;
  } list_res_t;
endpackage

// File: sv/gmt_cell.sv
// gossip membership table cell: one peer slot of the chain
// depends on gmt_pkg
module gmt_cell import gmt_pkg::*; (
  input  logic      clk,
  input  cell_cmd_t cmd,
  input  logic      live_i,
  input  logic      load_i,
  input  entry_t    prev_i,
  output entry_t    ent_o,
  output logic      hit_o,
  output logic      upd_o,
  output logic      failed_o,
  output logic      stale_o
);
  entry_t ent_r, ent_nxt;
  logic [31:0] age;

  assign age      = cmd.now - ent_r.stamp;
  assign hit_o    = live_i && (ent_r.id == cmd.key_id) && (ent_r.port == cmd.key_port);
  assign upd_o    = hit_o && (cmd.key_hb > ent_r.hb);
  assign failed_o = live_i && (age > {16'd0, cmd.fail});
  assign stale_o  = live_i && (age > {15'd0, cmd.limit});
  assign ent_o    = ent_r;

  always_comb begin
    ent_nxt = ent_r;
    if (load_i) begin
      ent_nxt = cmd.ins;
    end else if (cmd.shift) begin
      ent_nxt = prev_i;
    end else if (cmd.merge && upd_o) begin
      ent_nxt.hb    = cmd.key_hb;
      ent_nxt.stamp = cmd.now;
    end
  end

  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
  end
endmodule

// File: sv/gossip_membership_table.sv
// Heartbeat membership table built as a chain of peer cells; slot 0 (this
// node) is held in registers. One transaction is worked on at a time and the
// input stalls while busy. A merge has the accepting edge, then a step that
// compares the key against every cell at once and registers the status
// result. A tick or list request has the accepting edge, a step for the self
// entry, a step per peer in which the head word leaves the chain and is
// dropped if stale on a tick or re-entered behind the remaining peers (listed
// if not failed), and a closing step. A tick while not in the group goes
// straight to a single result with no entry. Each step that registers a result
// waits while the previous result is held under out_stall. Write configuration only idle.
// Depends on gmt_pkg and gmt_cell.
module gossip_membership_table import gmt_pkg::*; #(
  parameter int TABLE_DEPTH = TableDepthDef
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_action,
  input  logic [31:0] in_member_id,
  input  logic [15:0] in_member_port,
  input  logic [31:0] in_member_heartbeat,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_entry_valid,
  output logic [31:0] out_entry_id,
  output logic [15:0] out_entry_port,
  output logic [31:0] out_entry_heartbeat,
  output logic [31:0] out_list_time,
  output logic [2:0]  out_merge_status,
  output logic [3:0]  out_removed_count,
  output logic        out_last,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  localparam int NP = TABLE_DEPTH - 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_MERGE = 3'd1;
  localparam logic [2:0] ST_SELF  = 3'd2;
  localparam logic [2:0] ST_SCAN  = 3'd3;
  localparam logic [2:0] ST_ONE   = 3'd4;

  logic [15:0]   fail_r, rem_r;
  logic [31:0]   self_id_r;
  logic [15:0]   self_port_r;
  logic          intro_r;
  logic [CW-1:0] cnt_r, cnt_nxt, left_r, left_nxt, erem_r, erem_nxt;
  logic [31:0]   own_hb_r, own_hb_nxt, self_hb_r, self_hb_nxt, now_r, now_nxt;
  logic          joined_r, joined_nxt;
  logic [2:0]    st_r, st_nxt;
  logic          tick_r, tick_nxt;
  logic [31:0]   key_id_r, key_id_nxt, key_hb_r, key_hb_nxt;
  logic [15:0]   key_port_r, key_port_nxt;
  logic [3:0]    remc_r, remc_nxt;
  logic          ov_r, ov_nxt;
  list_res_t     res_r, res_nxt;

  cell_cmd_t     cmd;
  entry_t        chain [NP+1];
  logic [NP-1:0] hit, upd, failed, stale, live, ld;
  logic          out_free, acc, merge_go, scan_go, drop, room, ld_en;
  logic          any_hit, any_upd, self_hit, self_upd;
  logic [16:0]   limit;
  logic [CW-1:0] ld_pos, n_stale, n_emit;

  function automatic logic [CW-1:0] ones(input logic [NP-1:0] v);
    logic [CW-1:0] s;
    s = '0;
    for (int k = 0; k < NP; k++) s = s + CW'(v[k]);
    return s;
  endfunction

  assign out_free = !ov_r || !out_stall;
  assign in_stall = (st_r != ST_IDLE);
  assign acc      = in_valid && !in_stall;

  // chain[0] is the head; cell g holds slot g+1
  genvar g;
  generate
    for (g = 0; g < NP; g++) begin : g_cell
      assign live[g] = (CW'(g + 1) < cnt_r);
      assign ld[g]   = ld_en && (ld_pos == CW'(g + 1));
      gmt_cell u_cell (
        .clk(clk), .cmd(cmd), .live_i(live[g]), .load_i(ld[g]), .prev_i(chain[g+1]),
        .ent_o(chain[g]), .hit_o(hit[g]), .upd_o(upd[g]), .failed_o(failed[g]),
        .stale_o(stale[g])
      );
    end
  endgenerate
  assign chain[NP] = '0;

  assign limit    = {1'b0, fail_r} + {1'b0, rem_r};
  assign self_hit = (self_id_r == key_id_r) && (self_port_r == key_port_r);
  assign self_upd = self_hit && (key_hb_r > self_hb_r);
  assign any_hit  = self_hit || |hit;
  assign any_upd  = self_upd || |upd;
  assign room     = cnt_r < CW'(TABLE_DEPTH);
  assign merge_go = (st_r == ST_MERGE) && out_free;
  assign scan_go  = (st_r == ST_SCAN) && (left_r != '0) && out_free;
  assign drop     = tick_r && stale[0];
  // insert goes to slot cnt; a kept head re-enters behind the remaining peers
  assign ld_en    = (merge_go && !any_hit && room) || (scan_go && !drop);
  assign ld_pos   = (st_r == ST_MERGE) ? cnt_r : cnt_r - CW'(1);
  assign n_stale  = ones(stale);
  assign n_emit   = ones(live & ~failed);

  always_comb begin
    cmd.shift = scan_go; cmd.merge = merge_go;
    cmd.key_id = key_id_r; cmd.key_port = key_port_r; cmd.key_hb = key_hb_r;
    cmd.now = now_r; cmd.fail = fail_r; cmd.limit = limit;
    cmd.ins = chain[0];
    if (st_r == ST_MERGE) begin
      cmd.ins.id = key_id_r; cmd.ins.port = key_port_r;
      cmd.ins.hb = key_hb_r; cmd.ins.stamp = now_r;
    end
  end

  always_comb begin
    st_nxt = st_r; cnt_nxt = cnt_r; own_hb_nxt = own_hb_r; self_hb_nxt = self_hb_r;
    now_nxt = now_r; joined_nxt = joined_r; tick_nxt = tick_r;
    key_id_nxt = key_id_r; key_port_nxt = key_port_r; key_hb_nxt = key_hb_r;
    remc_nxt = remc_r; erem_nxt = erem_r; left_nxt = left_r;
    res_nxt = res_r; ov_nxt = ov_r && out_stall;
    case (st_r)
      ST_IDLE: if (acc) begin
        key_id_nxt = in_member_id; key_port_nxt = in_member_port;
        key_hb_nxt = in_member_heartbeat;
        tick_nxt = (in_action == ACT_TICK);
        case (in_action)
          ACT_MERGE: st_nxt = ST_MERGE;
          ACT_JOIN: begin
            joined_nxt = 1'b1;
            st_nxt = ST_MERGE;
          end
          ACT_TICK: begin
            if (joined_r || intro_r) begin
              own_hb_nxt = own_hb_r + 32'd1;
              self_hb_nxt = own_hb_r + 32'd1;
              st_nxt = ST_SELF;
            end else begin
              st_nxt = ST_ONE;
            end
          end
          default: st_nxt = ST_SELF;
        endcase
      end
      ST_MERGE: if (out_free) begin
        ov_nxt = 1'b1; res_nxt = '0; res_nxt.last = 1'b1;
        if (any_hit) begin
          res_nxt.ms = any_upd ? MS_UPD : MS_SAME;
          if (self_upd) self_hb_nxt = key_hb_r;
        end else if (room) begin
          res_nxt.ms = MS_INS;
          cnt_nxt = cnt_r + CW'(1);
        end else begin
          res_nxt.ms = MS_FULL;
        end
        st_nxt = ST_IDLE;
      end
      ST_SELF: if (out_free) begin
        ov_nxt = 1'b1; res_nxt = '0; res_nxt.ev = 1'b1;
        res_nxt.id = self_id_r; res_nxt.port = self_port_r; res_nxt.hb = self_hb_r;
        res_nxt.lt = now_r; res_nxt.rc = tick_r ? 4'(n_stale) : 4'd0;
        res_nxt.last = (n_emit == '0);
        remc_nxt = tick_r ? 4'(n_stale) : 4'd0;
        erem_nxt = n_emit;
        left_nxt = cnt_r - CW'(1);
        st_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        if (left_r == '0) begin
          st_nxt = ST_IDLE;
          if (tick_r) now_nxt = now_r + 32'd1;
        end else if (out_free) begin
          left_nxt = left_r - CW'(1);
          if (drop) cnt_nxt = cnt_r - CW'(1);
          if (!failed[0]) begin
            ov_nxt = 1'b1; res_nxt = '0; res_nxt.ev = 1'b1;
            res_nxt.id = chain[0].id; res_nxt.port = chain[0].port;
            res_nxt.hb = chain[0].hb; res_nxt.lt = now_r; res_nxt.rc = remc_r;
            res_nxt.last = (erem_r == CW'(1));
            erem_nxt = erem_r - CW'(1);
          end
        end
      end
      ST_ONE: if (out_free) begin
        ov_nxt = 1'b1; res_nxt = '0; res_nxt.last = 1'b1;
        now_nxt = now_r + 32'd1;
        st_nxt = ST_IDLE;
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fail_r <= 16'd5; rem_r <= 16'd20; self_id_r <= '0; self_port_r <= '0;
      intro_r <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FAIL:  fail_r <= cfg_data[15:0];
        REG_REM:   rem_r <= cfg_data[15:0];
        REG_ID:    self_id_r <= cfg_data;
        REG_PORT:  self_port_r <= cfg_data[15:0];
        REG_INTRO: intro_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE; cnt_r <= CW'(1); own_hb_r <= '0; self_hb_r <= '0;
      now_r <= '0; joined_r <= 1'b0; tick_r <= 1'b0;
      key_id_r <= '0; key_port_r <= '0; key_hb_r <= '0;
      remc_r <= '0; erem_r <= '0; left_r <= '0;
      ov_r <= 1'b0; res_r <= '0;
    end else begin
      st_r <= st_nxt; cnt_r <= cnt_nxt; own_hb_r <= own_hb_nxt; self_hb_r <= self_hb_nxt;
      now_r <= now_nxt; joined_r <= joined_nxt; tick_r <= tick_nxt;
      key_id_r <= key_id_nxt; key_port_r <= key_port_nxt; key_hb_r <= key_hb_nxt;
      remc_r <= remc_nxt; erem_r <= erem_nxt; left_r <= left_nxt;
      ov_r <= ov_nxt; res_r <= res_nxt;
    end
  end

  assign out_valid           = ov_r;
  assign out_entry_valid     = res_r.ev;
  assign out_entry_id        = res_r.id;
  assign out_entry_port      = res_r.port;
  assign out_entry_heartbeat = res_r.hb;
  assign out_list_time       = res_r.lt;
  assign out_merge_status    = res_r.ms;
  assign out_removed_count   = res_r.rc;
  assign out_last            = res_r.last;
endmodule

// File: sv/gmt_checker.sv
// port-level checks for the gossip membership table
// depends on gmt_pkg; bound to gossip_membership_table
module gmt_checker import gmt_pkg::*; (
  input logic clk, rst_n, in_valid, in_stall, out_valid, out_stall,
  input logic out_entry_valid, out_last,
  input logic [2:0] out_merge_status
);
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid) else $error("result dropped");
  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_merge_status != MS_NONE |-> !out_entry_valid && out_last)
    else $error("merge status on list entry");
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_merge_status <= MS_FULL) else $error("bad status");
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall) else $error("second transaction taken");
endmodule

bind gossip_membership_table gmt_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall),
  .out_entry_valid(out_entry_valid), .out_last(out_last),
  .out_merge_status(out_merge_status)
);
